[hdl/utf8_stream_validator_unit_assert.svh]
// Assertion macros for the UTF-8 stream validator.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define UTF8SV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8sv: next-cycle check failed");

`define UTF8SV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8sv: same-cycle check failed");

`else

`define UTF8SV_ASSERT_NEXT(label, ante, cons)

`define UTF8SV_ASSERT_NOW(label, ante, cons)

`endif

`endif

[hdl/utf8sv_pkg.sv]
package utf8sv_pkg;

  localparam logic [7:0] CONT_LOW  = 8'h80;
  localparam logic [7:0] CONT_HIGH = 8'hBF;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;

  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_E1   = 8'hE1;
  localparam logic [7:0] LEAD_EC   = 8'hEC;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD_EE   = 8'hEE;
  localparam logic [7:0] LEAD_EF   = 8'hEF;
  localparam logic [7:0] LEAD_F0   = 8'hF0;
  localparam logic [7:0] LEAD_F1   = 8'hF1;
  localparam logic [7:0] LEAD_F3   = 8'hF3;
  localparam logic [7:0] LEAD_F4   = 8'hF4;

  localparam logic [7:0] E0_LOW    = 8'hA0;
  localparam logic [7:0] ED_HIGH   = 8'h9F;
  localparam logic [7:0] F0_LOW    = 8'h90;
  localparam logic [7:0] F4_HIGH   = 8'h8F;

  typedef struct packed {
    logic       bad;
    logic [1:0] count;
    logic [7:0] low;
    logic [7:0] high;
  } lead_dec_t;

  // Classifies a byte seen where a new character is due.
  function automatic lead_dec_t decode_lead(input logic [7:0] b);
    lead_dec_t d;
    d = '{bad: 1'b0, count: 2'd0, low: CONT_LOW, high: CONT_HIGH};
    priority if (b == CHR_TAB || b == CHR_LF || b == CHR_CR ||
                 (b >= PRINT_LO && b <= PRINT_HI)) begin
      d.count = 2'd0;
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      d.count = 2'd1;
    end else if (b == LEAD_E0) begin
      d.count = 2'd2;
      d.low   = E0_LOW;
    end else if ((b >= LEAD_E1 && b <= LEAD_EC) || b == LEAD_EE || b == LEAD_EF) begin
      d.count = 2'd2;
    end else if (b == LEAD_ED) begin
      d.count = 2'd2;
      d.high  = ED_HIGH;
    end else if (b == LEAD_F0) begin
      d.count = 2'd3;
      d.low   = F0_LOW;
    end else if (b >= LEAD_F1 && b <= LEAD_F3) begin
      d.count = 2'd3;
    end else if (b == LEAD_F4) begin
      d.count = 2'd3;
      d.high  = F4_HIGH;
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage

[hdl/utf8_stream_validator_unit.sv]
// Channel | Direction | Signals                   | Payload
// s       | in        | s_tvalid s_tready s_tdata | data_byte, one string byte
// m       | out       | m_tvalid m_tready m_tdata | valid_res, one per zero byte
//
// One byte per cycle: a byte is captured in the input register, checked by
// range compares against the decoder state and, if it is the zero terminator,
// its verdict is written into the result register.
// A terminator transfer reaches its result through the input register, then the result register.
// rst clears the decoder state and the valid flags of both registers; their data is not reset.
// Only a terminator waiting on a full, stalled result register holds the input.
`include "utf8_stream_validator_unit_assert.svh"

module utf8_stream_validator_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);
  import utf8sv_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_fire;
  logic       s1_zero;

  logic [1:0] pending_count;
  logic [7:0] next_low;
  logic [7:0] next_high;
  logic       error_seen;

  logic [1:0] pending_count_next;
  logic [7:0] next_low_next;
  logic [7:0] next_high_next;
  logic       error_seen_next;

  logic       res_bit;
  lead_dec_t  lead;
  logic       cont_ok;

  assign s1_zero  = (s1_byte == CHR_NUL);
  // A terminator may only move on when the result register can take it.
  assign s1_fire  = s1_valid && (!s1_zero || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;

  assign lead    = decode_lead(s1_byte);
  assign cont_ok = (s1_byte >= next_low) && (s1_byte <= next_high);

  always_comb begin
    pending_count_next = pending_count;
    next_low_next      = next_low;
    next_high_next     = next_high;
    error_seen_next    = error_seen;
    priority if (s1_zero) begin
      pending_count_next = 2'd0;
      next_low_next      = CONT_LOW;
      next_high_next     = CONT_HIGH;
      error_seen_next    = 1'b0;
    end else if (pending_count == 2'd0) begin
      if (lead.bad) begin
        error_seen_next = 1'b1;
      end else if (lead.count != 2'd0) begin
        pending_count_next = lead.count;
        next_low_next      = lead.low;
        next_high_next     = lead.high;
      end
    end else begin
      // Any continuation restores the full range for the one after it.
      next_low_next  = CONT_LOW;
      next_high_next = CONT_HIGH;
      if (cont_ok) begin
        pending_count_next = pending_count - 2'd1;
      end else begin
        pending_count_next = 2'd0;
        error_seen_next    = 1'b1;
      end
    end
  end

  assign res_bit = !error_seen && (pending_count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
      pending_count <= 2'd0;
      next_low      <= CONT_LOW;
      next_high     <= CONT_HIGH;
      error_seen    <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (s1_fire) begin
        pending_count <= pending_count_next;
        next_low      <= next_low_next;
        next_high     <= next_high_next;
        error_seen    <= error_seen_next;
      end
      if (s1_fire && s1_zero) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_byte <= s_tdata;
    end
    if (s1_fire && s1_zero) begin
      m_tdata <= {7'd0, res_bit};
    end
  end

  `UTF8SV_ASSERT_NEXT(a_zero_gives_result, s1_fire && s1_zero, m_tvalid)
  `UTF8SV_ASSERT_NEXT(a_zero_clears_state, s1_fire && s1_zero,
                      pending_count == 2'd0 && !error_seen &&
                      next_low == CONT_LOW && next_high == CONT_HIGH)
  `UTF8SV_ASSERT_NOW(a_range_sane, 1'b1,
                     next_low[7] && next_high[7] && next_low <= next_high)
  `UTF8SV_ASSERT_NEXT(a_error_sticky, error_seen && !(s1_fire && s1_zero), error_seen)

endmodule
